>>> rtl/tagged_reading_frame_parser_macros.svh
// Assertion macros used by the top level of the tagged reading frame parser RTL.
`ifndef TAGGED_READING_FRAME_PARSER_MACROS_SVH
`define TAGGED_READING_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TRFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TRFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/trfp_pkg.sv
// Types and constants of the tagged reading frame parser.
package trfp_pkg;

	localparam int unsigned VALUE_W = 17;
	localparam int unsigned LIMIT_W = 3;
	localparam int unsigned KIND_W  = 2;

	localparam logic [LIMIT_W-1:0] DIGIT_CAP = 3'd5;
	localparam logic [LIMIT_W-1:0] TEMP_MAX_RESET  = 3'd4;
	localparam logic [LIMIT_W-1:0] VALUE_MAX_RESET = 3'd5;

	localparam logic REG_TEMP_MAX_DIGITS  = 1'b0;
	localparam logic REG_VALUE_MAX_DIGITS = 1'b1;

	localparam logic [7:0] CH_START = 8'h3C;
	localparam logic [7:0] CH_END   = 8'h3E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_TEMP  = 8'h54;
	localparam logic [7:0] CH_EC    = 8'h45;
	localparam logic [7:0] CH_PH    = 8'h50;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [KIND_W-1:0] KIND_TEMP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PH   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TAG  = 3'd1,
		PH_TEMP = 3'd2,
		PH_EC   = 3'd3,
		PH_PH   = 3'd4
	} phase_t;

	typedef struct packed {
		logic               valid;
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               frame_end;
	} result_t;

endpackage

>>> rtl/trfp_core.sv
// Parser state machine: phase, digit count and decimal accumulator.
module trfp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    rx_char,
	input  logic [trfp_pkg::LIMIT_W-1:0]  temp_limit,
	input  logic [trfp_pkg::LIMIT_W-1:0]  value_limit,
	output trfp_pkg::result_t             result
);
	import trfp_pkg::*;

	phase_t               phase_q, phase_d;
	logic [LIMIT_W-1:0]   count_q, count_d;
	logic [VALUE_W-1:0]   accum_q, accum_d;
	logic [LIMIT_W-1:0]   limit_raw, limit;
	logic [LIMIT_W-1:0]   count_inc;
	logic [VALUE_W-1:0]   accum_next;
	logic                 is_digit;
	logic                 is_close;
	logic                 in_field;

	assign is_digit  = (rx_char inside {[CH_ZERO:CH_NINE]});
	assign is_close  = (rx_char == CH_COMMA) || (rx_char == CH_END);
	assign in_field  = (phase_q == PH_TEMP) || (phase_q == PH_EC) || (phase_q == PH_PH);
	assign limit_raw = (phase_q == PH_TEMP) ? temp_limit : value_limit;
	assign limit     = (limit_raw > DIGIT_CAP) ? DIGIT_CAP : limit_raw;
	assign count_inc = count_q + LIMIT_W'(1);
	assign accum_next = {accum_q[VALUE_W-4:0], 3'b000} + {accum_q[VALUE_W-2:0], 1'b0}
		+ {{(VALUE_W-4){1'b0}}, rx_char[3:0]};

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		accum_d = accum_q;
		case (phase_q)
			PH_TAG: begin
				count_d = '0;
				accum_d = '0;
				case (rx_char)
					CH_TEMP: phase_d = PH_TEMP;
					CH_EC:   phase_d = PH_EC;
					CH_PH:   phase_d = PH_PH;
					default: phase_d = PH_TAG;
				endcase
			end
			PH_TEMP, PH_EC, PH_PH: begin
				if (is_digit) begin
					count_d = count_inc;
					if (count_inc > limit) begin
						phase_d = PH_IDLE;
					end else begin
						accum_d = accum_next;
					end
				end else if (rx_char == CH_COMMA) begin
					phase_d = PH_TAG;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = (rx_char == CH_START) ? PH_TAG : PH_IDLE;
			end
		endcase
	end

	always_comb begin
		result.valid     = in_field && is_close;
		result.value     = accum_q;
		result.frame_end = (rx_char == CH_END);
		case (phase_q)
			PH_TEMP: result.kind = KIND_TEMP;
			PH_EC:   result.kind = KIND_EC;
			PH_PH:   result.kind = KIND_PH;
			default: result.kind = KIND_TEMP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			accum_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			accum_q <= accum_d;
		end
	end

endmodule

>>> rtl/tagged_reading_frame_parser.sv
// Top level of the tagged reading frame parser: input stage, config and result register.
// The input stage and result register each hold one item; a field's result is registered
// when its closing byte leaves the input stage. Bytes enter one per cycle unless in_stall.
// in_stall rises only while the result register is full and stalled with a byte waiting.
// Reset: parser idle waiting for '<', accumulator cleared, digit limits 4 (T) and 5 (E, P).
module tagged_reading_frame_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [trfp_pkg::KIND_W-1:0]   reading_kind,
	output logic [trfp_pkg::VALUE_W-1:0]  field_value,
	output logic                          frame_end,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [trfp_pkg::LIMIT_W-1:0]  cfg_wdata
);
	import trfp_pkg::*;
	`include "tagged_reading_frame_parser_macros.svh"

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic [LIMIT_W-1:0]   temp_max_q;
	logic [LIMIT_W-1:0]   value_max_q;
	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 end_q;
	logic                 out_free;
	logic                 advance;
	result_t              result;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	trfp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_char     (byte_s1),
		.temp_limit  (temp_max_q),
		.value_limit (value_max_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_max_q  <= TEMP_MAX_RESET;
			value_max_q <= VALUE_MAX_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_TEMP_MAX_DIGITS) begin
				temp_max_q <= cfg_wdata;
			end else begin
				value_max_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			kind_q  <= result.kind;
			value_q <= result.value;
			end_q   <= result.frame_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign reading_kind = kind_q;
	assign field_value  = value_q;
	assign frame_end    = end_q;

	`TRFP_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1 && out_valid_q, "stall without held item")
	`TRFP_ASSERT_NOW(a_kind_legal, out_valid, reading_kind != 2'd3, "illegal reading kind")
	`TRFP_ASSERT_NOW(a_value_range, out_valid, field_value <= 17'd99999, "reading value overflow")
	`TRFP_ASSERT_NEXT(a_s1_hold, valid_s1 && !out_free, valid_s1 && $stable(byte_s1), "input stage lost")

endmodule

>>> test/tb.sv
// Testbench for the tagged reading frame parser: framed byte traffic, predicted readings, limits.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int BYTES_PER_PHASE = 205;

	class frame_parse_tracker;
		logic [LIMIT_W-1:0] temp_limit;
		logic [LIMIT_W-1:0] value_limit;
		phase_t             phase;
		logic [2:0]         digits;
		logic [VALUE_W-1:0] accum;
		result_t            due_readings[$];
		int                 errors;

		function new();
			temp_limit = TEMP_MAX_RESET;
			value_limit = VALUE_MAX_RESET;
			phase = PH_IDLE;
			digits = '0;
			accum = '0;
			errors = 0;
		endfunction

		function void set_limit(logic idx, logic [LIMIT_W-1:0] val);
			if (idx == REG_TEMP_MAX_DIGITS) begin
				temp_limit = val;
			end else begin
				value_limit = val;
			end
		endfunction

		function int pending();
			return due_readings.size();
		endfunction

		// advance the parse state by one transferred byte
		function void take_byte(logic [7:0] c);
			logic [LIMIT_W-1:0] lim;
			result_t            r;
			case (phase)
				PH_TAG: begin
					digits = '0;
					accum = '0;
					if (c == CH_TEMP) begin
						phase = PH_TEMP;
					end else if (c == CH_EC) begin
						phase = PH_EC;
					end else if (c == CH_PH) begin
						phase = PH_PH;
					end
				end
				PH_TEMP, PH_EC, PH_PH: begin
					lim = (phase == PH_TEMP) ? temp_limit : value_limit;
					if (lim > DIGIT_CAP) begin
						lim = DIGIT_CAP;
					end
					if (c >= CH_ZERO && c <= CH_NINE) begin
						digits = digits + 3'd1;
						if (digits > lim) begin
							phase = PH_IDLE;
						end else begin
							accum = VALUE_W'(accum * 10 + (c - CH_ZERO));
						end
					end else if (c == CH_COMMA || c == CH_END) begin
						r.valid = 1'b1;
						case (phase)
							PH_TEMP: r.kind = KIND_TEMP;
							PH_EC:   r.kind = KIND_EC;
							default: r.kind = KIND_PH;
						endcase
						r.value = accum;
						r.frame_end = (c == CH_END);
						due_readings.push_back(r);
						phase = (c == CH_COMMA) ? PH_TAG : PH_IDLE;
					end else begin
						phase = PH_IDLE;
					end
				end
				default: begin
					phase = (c == CH_START) ? PH_TAG : PH_IDLE;
				end
			endcase
		endfunction

		function void match_reading(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
				logic fend);
			result_t r;
			if (due_readings.size() == 0) begin
				$error("reading with none expected: kind %0d value %0d frame_end %0d",
					kind, value, fend);
				errors++;
				return;
			end
			r = due_readings.pop_front();
			if (kind !== r.kind) begin
				$error("reading_kind: expected %0d, got %0d", r.kind, kind);
				errors++;
			end
			if (value !== r.value) begin
				$error("field_value: expected %0d, got %0d", r.value, value);
				errors++;
			end
			if (fend !== r.frame_end) begin
				$error("frame_end: expected %0d, got %0d", r.frame_end, fend);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [KIND_W-1:0]    reading_kind;
	logic [VALUE_W-1:0]   field_value;
	logic                 frame_end;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [LIMIT_W-1:0]   cfg_wdata;

	frame_parse_tracker tracker = new();
	logic [7:0]         rx_stream[$];
	int                 burst_left;
	int                 cycles;
	int                 stall_mode;
	int                 stall_run;

	tagged_reading_frame_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reading_kind  (reading_kind),
		.field_value   (field_value),
		.frame_end     (frame_end),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.match_reading(reading_kind, field_value, frame_end);
		end
	end

	initial begin
		out_stall = 1'b0;
		stall_run = 0;
		forever begin
			@(negedge clk);
			if (stall_run == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_run = $urandom_range(20, 150);
			end
			stall_run--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= stall_run[3];
			endcase
		end
	end

	task automatic send_stream();
		int gap;
		foreach (rx_stream[i]) begin
			@(negedge clk);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			in_valid <= 1'b1;
			rx_byte <= rx_stream[i];
			do @(posedge clk); while (in_stall);
			tracker.take_byte(rx_stream[i]);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_limit(idx, val);
	endtask

	// one frame of up to four fields, or a short run of line noise
	function automatic void add_frame(input int tlim, input int vlim);
		int         nfields;
		int         ndig;
		int         lim;
		int         roll;
		logic [7:0] tag;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
			return;
		end
		rx_stream.push_back(CH_START);
		nfields = $urandom_range(1, 4);
		for (int f = 0; f < nfields; f++) begin
			if ($urandom_range(0, 9) == 0) begin
				rx_stream.push_back(8'($urandom_range(0, 255)));
			end
			case ($urandom_range(0, 2))
				0: tag = CH_TEMP;
				1: tag = CH_EC;
				default: tag = CH_PH;
			endcase
			rx_stream.push_back(tag);
			lim = (tag == CH_TEMP) ? tlim : vlim;
			ndig = ($urandom_range(0, 9) == 0) ? lim + 1 : $urandom_range(0, lim);
			for (int d = 0; d < ndig; d++) begin
				rx_stream.push_back((roll < 30) ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
			end
			if (roll >= 90 && $urandom_range(0, 2) == 0) begin
				rx_stream.push_back(8'($urandom_range(0, 255)));
			end
			rx_stream.push_back((f == nfields - 1) ? CH_END : CH_COMMA);
		end
	endfunction

	initial begin
		int    temp_sets[PHASES];
		int    value_sets[PHASES];
		int    tlim;
		int    vlim;
		string lead;
		temp_sets = '{4, 1, 5, 0, 7, 2, 5, 3};
		value_sets = '{5, 1, 5, 0, 6, 3, 0, 7};
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP_MAX_DIGITS;
		cfg_wdata = '0;
		burst_left = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// junk in idle, unknown tag, empty field, widest value, digit overflow, bad char
		lead = "<Q>T><E99999,P,T12345<P7x";
		rx_stream.push_back(8'h00);
		rx_stream.push_back(8'hFF);
		for (int i = 0; i < lead.len(); i++) rx_stream.push_back(lead.getc(i));
		send_stream();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				write_limit(REG_TEMP_MAX_DIGITS, LIMIT_W'(temp_sets[p]));
				write_limit(REG_VALUE_MAX_DIGITS, LIMIT_W'(value_sets[p]));
			end
			tlim = (temp_sets[p] > 5) ? 5 : temp_sets[p];
			vlim = (value_sets[p] > 5) ? 5 : value_sets[p];
			rx_stream.delete();
			while (rx_stream.size() < BYTES_PER_PHASE) add_frame(tlim, vlim);
			send_stream();
			drain();
		end

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/trfp_pkg.sv
rtl/trfp_core.sv
rtl/tagged_reading_frame_parser.sv
test/tb.sv
